>>> src/bfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared constants, codes and encoder functions of the page frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  // Geometry of the frame store
  localparam int MAX_PAGES   = 32768;
  localparam int PAGE_BYTES  = 4096;
  localparam int WORD_BITS   = 32;
  localparam int DEPTH       = MAX_PAGES / WORD_BITS;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
  localparam int PAGE_W      = $clog2(MAX_PAGES);
  localparam int CNT_W       = ADDR_W + 1;

  // Two-level summary of non-full words
  localparam int GROUP_SIZE  = 32;
  localparam int GROUPS      = DEPTH / GROUP_SIZE;
  localparam int GRP_W       = $clog2(GROUPS);
  localparam int SEL_W       = $clog2(GROUP_SIZE);

  // Port widths
  localparam int BC_W        = 16;
  localparam int BYTE_ADDR_W = 32;
  localparam int PAGE_ADDR_W = 27;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_MARK  = 2'd2,
    CMD_INIT  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_OOM   = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WORD,
    ST_ALLOC,
    ST_MOD,
    ST_INIT
  } state_t;

  // Lowest set bit of the group summary
  function automatic logic [GRP_W-1:0] first_set_grp(input logic [GROUPS-1:0] v);
    logic [GRP_W-1:0] idx;
    idx = '0;
    for (int i = GROUPS - 1; i >= 0; i--) begin
      if (v[i]) idx = GRP_W'(i);
    end
    return idx;
  endfunction

  // Lowest set bit among the words of one group
  function automatic logic [SEL_W-1:0] first_set_sel(input logic [GROUP_SIZE-1:0] v);
    logic [SEL_W-1:0] idx;
    idx = '0;
    for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
      if (v[i]) idx = SEL_W'(i);
    end
    return idx;
  endfunction

  // Lowest set bit of a bitmap word
  function automatic logic [BIT_W-1:0] first_set_bit(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

>>> src/bfa_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 10
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  localparam int Words = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [Words];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> src/bitmap_page_frame_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator
// First-fit page frame allocator over a bitmap kept in block RAM.
// ----------------------------------------------------------------------------
// Commands are taken when start is high and busy is low; each one gives a
// single result word on page_addr/status, flagged by a one-cycle done pulse
// that the receiver cannot hold off. For an allocate, a register of
// per-word "not full" flags, summarized per group of 32 words, picks the
// first word with a free page (or answers out of memory), then one RAM read
// and a priority encode pick the bit. Free and mark-used read, modify and
// write back the word, or answer with a range status when the address is
// beyond the store. Init writes one RAM word per cycle over the scanned
// words. After reset a clearing pass sets each of the 1024 bitmap words
// to all used; busy stays high during it. The block_count register can
// be written at any time through cfg_valid/cfg_ready but should only change
// while no command is in flight.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // command channel
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [bfa_pkg::CMD_W-1:0]       cmd,
  input  wire logic [bfa_pkg::BYTE_ADDR_W-1:0] byte_addr,
  // result channel
  output logic                                 done,
  output logic      [bfa_pkg::PAGE_ADDR_W-1:0] page_addr,
  output logic      [bfa_pkg::STATUS_W-1:0]    status,
  // configuration write channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bfa_pkg::BC_W-1:0]        cfg_data
);

  import bfa_pkg::*;

  localparam logic [WORD_BITS-1:0] OneBit = WORD_BITS'(1);

  state_t                 state, state_next;
  logic [CNT_W-1:0]       cnt, cnt_next;
  logic [BC_W-1:0]        block_count;
  logic [DEPTH-1:0]       nf;           // word has at least one free page
  logic [GRP_W-1:0]       grp;
  logic                   grp_any;
  logic [ADDR_W-1:0]      widx, widx_next;
  logic [BIT_W-1:0]       bidx, bidx_next;
  cmd_t                   op, op_next;
  logic                   done_next;
  status_t                status_next;
  logic [PAGE_ADDR_W-1:0] page_next;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [WORD_BITS-1:0]   ram_wdata;
  logic                   ram_re;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [WORD_BITS-1:0]   ram_rdata;

  logic                   nf_we;
  logic [ADDR_W-1:0]      nf_idx;
  logic                   nf_val;

  logic [GROUPS-1:0]      grp_free;
  logic [GROUP_SIZE-1:0]  grp_words;
  logic [ADDR_W-1:0]      word_hit;
  logic [BC_W-BIT_W-1:0]  bc_words;
  logic [CNT_W-1:0]       scan_n;
  logic                   addr_oob;
  logic [ADDR_W-1:0]      addr_word;
  logic [BIT_W-1:0]       addr_bit;
  logic [BIT_W-1:0]       alloc_bit;
  cmd_t                   cmd_in;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign cmd_in    = cmd_t'(cmd);

  // Bitmap store
  bfa_ram #(
    .DATA_W (WORD_BITS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Group summary of non-full words
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_free[g] = |nf[g*GROUP_SIZE +: GROUP_SIZE];
    end
  end

  assign grp_words = nf[{grp, {SEL_W{1'b0}}} +: GROUP_SIZE];
  assign word_hit  = {grp, first_set_sel(grp_words)};

  // Number of words covered by allocate and init, clamped to the store
  assign bc_words = block_count[BC_W-1:BIT_W];
  assign scan_n   = (bc_words > (BC_W-BIT_W)'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(bc_words);

  // Page address decode
  assign addr_oob  = |byte_addr[BYTE_ADDR_W-1:PAGE_SHIFT+PAGE_W];
  assign addr_word = byte_addr[PAGE_SHIFT+PAGE_W-1:PAGE_SHIFT+BIT_W];
  assign addr_bit  = byte_addr[PAGE_SHIFT+BIT_W-1:PAGE_SHIFT];

  assign alloc_bit = first_set_bit(~ram_rdata);

  // State register and data registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      cnt         <= '0;
      done        <= 1'b0;
      block_count <= '0;
      nf          <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= done_next;
      if (cfg_valid && cfg_ready) begin
        block_count <= cfg_data;
      end
      if (nf_we) begin
        nf[nf_idx] <= nf_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    widx      <= widx_next;
    bidx      <= bidx_next;
    op        <= op_next;
    page_addr <= page_next;
    status    <= status_next;
    if (state == ST_IDLE) begin
      grp     <= first_set_grp(grp_free);
      grp_any <= |grp_free;
    end
  end

  // Next state, RAM and summary control
  always_comb begin
    logic [WORD_BITS-1:0] new_word;
    logic [WORD_BITS-1:0] mask;

    state_next  = state;
    cnt_next    = cnt;
    widx_next   = widx;
    bidx_next   = bidx;
    op_next     = op;
    done_next   = 1'b0;
    status_next = STAT_OK;
    page_next   = '0;
    ram_we      = 1'b0;
    ram_waddr   = widx;
    ram_wdata   = '1;
    ram_re      = 1'b0;
    ram_raddr   = addr_word;
    nf_we       = 1'b0;
    nf_idx      = widx;
    nf_val      = 1'b0;
    new_word    = '1;
    mask        = '0;

    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt[ADDR_W-1:0];
        if (cnt[ADDR_W-1:0] == ADDR_W'(DEPTH - 1)) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      ST_IDLE: begin
        if (start) begin
          op_next = cmd_in;
          case (cmd_in) inside
            CMD_ALLOC: begin
              state_next = ST_WORD;
            end
            CMD_FREE, CMD_MARK: begin
              if (addr_oob) begin
                done_next   = 1'b1;
                status_next = STAT_RANGE;
              end else begin
                ram_re     = 1'b1;
                widx_next  = addr_word;
                bidx_next  = addr_bit;
                state_next = ST_MOD;
              end
            end
            default: begin
              cnt_next   = '0;
              state_next = ST_INIT;
            end
          endcase
        end
      end

      // first non-full word must lie inside the scanned range
      ST_WORD: begin
        if (!grp_any || ({1'b0, word_hit} >= scan_n)) begin
          done_next   = 1'b1;
          status_next = STAT_OOM;
          state_next  = ST_IDLE;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = word_hit;
          widx_next  = word_hit;
          state_next = ST_ALLOC;
        end
      end

      // take the lowest clear bit and write the word back
      ST_ALLOC: begin
        mask        = OneBit << alloc_bit;
        new_word    = ram_rdata | mask;
        ram_we      = 1'b1;
        ram_wdata   = new_word;
        nf_we       = 1'b1;
        nf_val      = ~&new_word;
        done_next   = 1'b1;
        page_next   = PAGE_ADDR_W'({widx, alloc_bit, {PAGE_SHIFT{1'b0}}});
        state_next  = ST_IDLE;
      end

      ST_MOD: begin
        mask = OneBit << bidx;
        if (op == CMD_FREE) begin
          new_word = ram_rdata & ~mask;
        end else begin
          new_word = ram_rdata | mask;
        end
        ram_we     = 1'b1;
        ram_wdata  = new_word;
        nf_we      = 1'b1;
        nf_val     = ~&new_word;
        done_next  = 1'b1;
        state_next = ST_IDLE;
      end

      ST_INIT: begin
        if (cnt == scan_n) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = cnt[ADDR_W-1:0];
          nf_we     = 1'b1;
          nf_idx    = cnt[ADDR_W-1:0];
          nf_val    = 1'b0;
          cnt_next  = cnt + 1'b1;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // Summary flags must agree with the RAM: the chosen word has a free page
  a_alloc_not_full: assert property (@(posedge clk) disable iff (rst)
    state == ST_ALLOC |-> !(&ram_rdata))
    else $error("allocate picked a full word");

  // Only a successful allocate reports a page address
  a_page_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status != STAT_OK) |-> page_addr == '0)
    else $error("page address set on failed command");

  // Accesses never overlap on one word
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("read and write to the same word");

  // A result follows an accepted command or work in progress
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(busy) || $past(start))
    else $error("result without a command");
`endif

endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit bitmap page frame allocator.
// ----------------------------------------------------------------------------
// A scripted opening drives each command and the corner addresses and block
// counts. Random traffic follows over a series of block counts. A shadow
// bitmap predicts each result word. Every done pulse is checked against the
// oldest owed result.
// ----------------------------------------------------------------------------
module tb;
  import bfa_pkg::*;

  localparam int CYCLE_LIMIT    = 4_000_000;
  localparam int ITEMS_PER_PASS = 130;

  // One result word: byte address of the granted page plus status
  typedef struct packed {
    logic [PAGE_ADDR_W-1:0] page;
    status_t                stat;
  } alloc_result_t;

  // Scripted step: a block count write, or a command with an optional known answer
  typedef struct packed {
    bit                     is_cfg;
    cmd_t                   op;
    logic [31:0]            arg;
    bit                     known;
    logic [PAGE_ADDR_W-1:0] page;
    status_t                stat;
  } script_row_t;

  localparam int N_SCRIPT = 31;

  script_row_t script [N_SCRIPT] = '{
    // block count 0 after reset: nothing is scanned
    '{1'b0, CMD_ALLOC, 32'h0000_0000, 1'b1, 27'h000_0000, STAT_OOM},
    '{1'b0, CMD_INIT,  32'h0000_0000, 1'b1, 27'h000_0000, STAT_OK},
    '{1'b0, CMD_FREE,  32'h0000_0000, 1'b1, 27'h000_0000, STAT_OK},
    '{1'b0, CMD_ALLOC, 32'h0000_0000, 1'b1, 27'h000_0000, STAT_OOM},
    // full store
    '{1'b1, CMD_ALLOC, 32'd32768,     1'b0, 27'h000_0000, STAT_OK},
    '{1'b0, CMD_ALLOC, 32'h0000_0000, 1'b1, 27'h000_0000, STAT_OK},
    '{1'b0, CMD_ALLOC, 32'h0000_0000, 1'b1, 27'h000_0000, STAT_OOM},
    '{1'b0, CMD_FREE,  32'h07FF_FFFF, 1'b1, 27'h000_0000, STAT_OK},
    '{1'b0, CMD_FREE,  32'h0800_0000, 1'b1, 27'h000_0000, STAT_RANGE},
    '{1'b0, CMD_MARK,  32'hFFFF_FFFF, 1'b1, 27'h000_0000, STAT_RANGE},
    '{1'b0, CMD_ALLOC, 32'h0000_0000, 1'b1, 27'h7FF_F000, STAT_OK},
    '{1'b0, CMD_FREE,  32'h0000_5FFF, 1'b1, 27'h000_0000, STAT_OK},
    '{1'b0, CMD_FREE,  32'h0000_3000, 1'b1, 27'h000_0000, STAT_OK},
    '{1'b0, CMD_ALLOC, 32'h0000_0000, 1'b1, 27'h000_3000, STAT_OK},
    '{1'b0, CMD_MARK,  32'h0000_5123, 1'b1, 27'h000_0000, STAT_OK},
    '{1'b0, CMD_ALLOC, 32'h0000_0000, 1'b1, 27'h000_0000, STAT_OOM},
    // block count past the store: scan stops at the last word
    '{1'b1, CMD_ALLOC, 32'd65535,     1'b0, 27'h000_0000, STAT_OK},
    '{1'b0, CMD_FREE,  32'h07FF_E000, 1'b1, 27'h000_0000, STAT_OK},
    '{1'b0, CMD_ALLOC, 32'h0000_0000, 1'b1, 27'h7FF_E000, STAT_OK},
    '{1'b0, CMD_FREE,  32'h0004_0000, 1'b1, 27'h000_0000, STAT_OK},
    // free page sits just above the scanned words, then comes into range
    '{1'b1, CMD_ALLOC, 32'd64,        1'b0, 27'h000_0000, STAT_OK},
    '{1'b0, CMD_ALLOC, 32'h0000_0000, 1'b1, 27'h000_0000, STAT_OOM},
    '{1'b1, CMD_ALLOC, 32'd95,        1'b0, 27'h000_0000, STAT_OK},
    '{1'b0, CMD_ALLOC, 32'h0000_0000, 1'b1, 27'h000_0000, STAT_OOM},
    '{1'b1, CMD_ALLOC, 32'd96,        1'b0, 27'h000_0000, STAT_OK},
    '{1'b0, CMD_ALLOC, 32'h0000_0000, 1'b1, 27'h004_0000, STAT_OK},
    '{1'b0, CMD_FREE,  32'h0000_0ABC, 1'b0, 27'h000_0000, STAT_OK},
    '{1'b0, CMD_INIT,  32'h0000_0000, 1'b1, 27'h000_0000, STAT_OK},
    '{1'b0, CMD_FREE,  32'h0000_1000, 1'b1, 27'h000_0000, STAT_OK},
    // a count below one word scans nothing
    '{1'b1, CMD_ALLOC, 32'd31,        1'b0, 27'h000_0000, STAT_OK},
    '{1'b0, CMD_ALLOC, 32'h0000_0000, 1'b1, 27'h000_0000, STAT_OOM}
  };

  localparam int N_PASSES = 10;
  int pass_counts [N_PASSES] = '{32768, 64, 0, 65535, 100, 31, 1024, 4096, 32767, 32768};

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic [CMD_W-1:0]       cmd = '0;
  logic [BYTE_ADDR_W-1:0] byte_addr = '0;
  logic                   done;
  logic [PAGE_ADDR_W-1:0] page_addr;
  logic [STATUS_W-1:0]    status;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [BC_W-1:0]        cfg_data = '0;

  // Shadow copy of the allocator state
  bit   [WORD_BITS-1:0]   frame_map [DEPTH];
  bit   [BC_W-1:0]        pool_pages;

  alloc_result_t          owed_results [$];
  int                     errors = 0;
  int                     cycle_count = 0;

  bitmap_page_frame_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .byte_addr (byte_addr),
    .done      (done),
    .page_addr (page_addr),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Predict one command's result word and update the shadow bitmap
  function automatic alloc_result_t predict_alloc_result(cmd_t op, logic [31:0] addr);
    alloc_result_t r;
    int unsigned   words;
    int unsigned   pg;
    bit            hit;
    r = '0;
    words = pool_pages / WORD_BITS;
    if (words > DEPTH) words = DEPTH;
    case (op)
      CMD_ALLOC: begin
        hit = 1'b0;
        for (int w = 0; w < words && !hit; w++) begin
          if (frame_map[w] != '1) begin
            for (int b = 0; b < WORD_BITS; b++) begin
              if (!frame_map[w][b]) begin
                frame_map[w][b] = 1'b1;
                r.page = PAGE_ADDR_W'((w * WORD_BITS + b) * PAGE_BYTES);
                hit = 1'b1;
                break;
              end
            end
          end
        end
        if (!hit) r.stat = STAT_OOM;
      end
      CMD_FREE, CMD_MARK: begin
        pg = addr / PAGE_BYTES;
        if (pg >= MAX_PAGES) begin
          r.stat = STAT_RANGE;
        end else begin
          frame_map[pg / WORD_BITS][pg % WORD_BITS] = (op == CMD_MARK);
        end
      end
      default: begin
        for (int w = 0; w < words; w++) frame_map[w] = '1;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("tb: mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    errors++;
  endtask

  // Present one command word from a falling edge; hold it until taken
  task automatic issue_cmd(input cmd_t op, input logic [31:0] addr, input bit known,
                           input logic [PAGE_ADDR_W-1:0] kpage, input status_t kstat);
    alloc_result_t predicted;
    alloc_result_t typed;
    start = 1'b1;
    cmd = op;
    byte_addr = addr;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = predict_alloc_result(op, addr);
    typed.page = kpage;
    typed.stat = kstat;
    owed_results.push_back(known ? typed : predicted);
    @(negedge clk);
  endtask

  // Wait until every owed result is in and the block is quiet
  task automatic settle_idle();
    while (owed_results.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_pool_size(input logic [BC_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pool_pages = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Result checker
  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst && done) begin
      if (owed_results.size() == 0) begin
        report_mismatch("result word with none owed", 32'({page_addr, status}), '0);
      end else begin
        want = owed_results.pop_front();
        if (page_addr !== want.page)
          report_mismatch("page_addr", 32'(page_addr), 32'(want.page));
        if (status !== want.stat)
          report_mismatch("status", 32'(status), 32'(want.stat));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    int           burst;
    int           scan_pages;
    int           r;
    logic [19:0]  pg;
    logic [31:0]  addr;
    cmd_t         op;
    for (int w = 0; w < DEPTH; w++) frame_map[w] = '1;
    pool_pages = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Scripted opening
    for (int i = 0; i < N_SCRIPT; i++) begin
      if (script[i].is_cfg) begin
        start = 1'b0;
        settle_idle();
        write_pool_size(script[i].arg[BC_W-1:0]);
      end else begin
        issue_cmd(script[i].op, script[i].arg, script[i].known, script[i].page,
                  script[i].stat);
        if ($urandom_range(1) == 0) begin
          start = 1'b0;
          repeat ($urandom_range(3, 1)) @(negedge clk);
        end
      end
    end

    // Random traffic, one pass per block count
    for (int p = 0; p < N_PASSES; p++) begin
      start = 1'b0;
      settle_idle();
      write_pool_size(BC_W'(pass_counts[p]));
      scan_pages = (pool_pages / WORD_BITS) * WORD_BITS;
      if (scan_pages > MAX_PAGES) scan_pages = MAX_PAGES;
      burst = $urandom_range(8, 1);
      for (int k = 0; k < ITEMS_PER_PASS; k++) begin
        r = $urandom_range(99);
        if (r < 40)      op = CMD_ALLOC;
        else if (r < 75) op = CMD_FREE;
        else if (r < 95) op = CMD_MARK;
        else             op = CMD_INIT;

        // mostly pages inside the scanned words, some anywhere, some past the store
        r = $urandom_range(99);
        if (r < 70)      pg = 20'($urandom_range(scan_pages > 0 ? scan_pages - 1 : 63));
        else if (r < 85) pg = 20'($urandom_range(MAX_PAGES - 1));
        else             pg = 20'($urandom_range(20'hF_FFFF, MAX_PAGES));
        addr = {pg, 12'($urandom())};
        if (r >= 95) addr = $urandom();

        issue_cmd(op, addr, 1'b0, '0, STAT_OK);

        // sender bursts: short ones with gaps, now and then a long unbroken run
        burst--;
        if (burst == 0) begin
          burst = ($urandom_range(3) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
          if ($urandom_range(3) != 0) begin
            start = 1'b0;
            repeat ($urandom_range(6, 1)) @(negedge clk);
          end
        end
      end
    end

    start = 1'b0;
    settle_idle();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
src/bfa_pkg.sv
src/bfa_ram.sv
src/bitmap_page_frame_allocator.sv
bench/tb.sv
